// ===== rtl/psic_pkg.sv =====
// Shared types and constants for the piecewise surface intensity correction block.
// Used by psic_ctrl, psic_datapath and the top level; depends on nothing.
`default_nettype none
package psic_pkg;

  localparam int DEGREE_X    = 2;
  localparam int DEGREE_Y    = 2;
  localparam int SEGMENTS    = 3;
  localparam int TERMS       = (DEGREE_X + 1) * (DEGREE_Y + 1);
  localparam int TABLE_DEPTH = SEGMENTS * TERMS;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int TERM_W = $clog2(TERMS);
  localparam int IX_W   = $clog2(DEGREE_X + 1);
  localparam int JY_W   = $clog2(DEGREE_Y + 1);
  localparam int QUO_W  = 16;
  localparam int KDIV_W = $clog2(QUO_W);

  // Configuration register indexes.
  localparam logic [1:0] REG_NEAR_LIMIT = 2'd0;
  localparam logic [1:0] REG_FAR_LIMIT  = 2'd1;
  localparam logic [1:0] REG_REF_GAIN   = 2'd2;

  localparam logic [15:0] NEAR_LIMIT_RST = 16'd1459;
  localparam logic [15:0] FAR_LIMIT_RST  = 16'd3635;
  localparam logic [15:0] REF_GAIN_RST   = 16'd57016;

  // Request kinds carried in the input tuser.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_CORRECT = 1'b1;

  typedef struct packed {
    logic              load_point;
    logic              write_coef;
    logic              fetch;
    logic              mul1;
    logic              mul2;
    logic              acc;
    logic              row_end;
    logic              div_init;
    logic              div_step;
    logic              out_load;
    logic [TERM_W-1:0] term;
    logic [KDIV_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic skip_div;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/psic_ctrl.sv =====
// Sequencer for the correction block: walks the polynomial terms and the divider steps.
// Depends on psic_pkg; drives psic_datapath through cmd_t and reads status_t.
`default_nettype none
module psic_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  input  wire                      in_mode_i,
  output logic                     in_ready_o,
  input  wire  psic_pkg::status_t  status_i,
  output psic_pkg::cmd_t           cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FETCH = 8'b0000_0010,
    S_MUL1  = 8'b0000_0100,
    S_MUL2  = 8'b0000_1000,
    S_ACC   = 8'b0001_0000,
    S_DIV0  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e                      state_q, state_d;
  logic [psic_pkg::IX_W-1:0]   i_q, i_d;
  logic [psic_pkg::JY_W-1:0]   j_q, j_d;
  logic [psic_pkg::TERM_W-1:0] term_q, term_d;
  logic [psic_pkg::KDIV_W-1:0] k_q, k_d;
  logic                        accept;
  logic                        row_end;
  logic                        last_term;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign row_end    = (j_q == psic_pkg::JY_W'(psic_pkg::DEGREE_Y));
  assign last_term  = row_end && (i_q == psic_pkg::IX_W'(psic_pkg::DEGREE_X));

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    term_d  = term_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.term = term_q;
    cmd_o.k    = k_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_mode_i == psic_pkg::MODE_LOAD) begin
            cmd_o.write_coef = 1'b1;
          end else begin
            cmd_o.load_point = 1'b1;
            i_d     = '0;
            j_d     = '0;
            term_d  = '0;
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc     = 1'b1;
        cmd_o.row_end = row_end;
        term_d = term_q + 1'b1;
        if (row_end) begin
          j_d = '0;
          i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
        state_d = last_term ? S_DIV0 : S_FETCH;
      end
      S_DIV0: begin
        cmd_o.div_init = 1'b1;
        k_d = psic_pkg::KDIV_W'(psic_pkg::QUO_W - 1);
        state_d = status_i.skip_div ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        k_d = k_q - 1'b1;
        if (k_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      term_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      term_q  <= term_d;
      k_q     <= k_d;
    end
  end

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("result loaded while output register busy");

  a_point_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_mode_i == psic_pkg::MODE_CORRECT) |=> (state_q == S_FETCH && term_q == '0))
    else $error("point request did not start at the first term");

  a_terms_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && last_term) |=>
      (state_q == S_DIV0 && term_q == psic_pkg::TERM_W'(psic_pkg::TERMS)))
    else $error("term walk ended at the wrong count");

endmodule
`default_nettype wire

// ===== rtl/psic_datapath.sv =====
// Datapath of the correction block: coefficient memory, polynomial arithmetic,
// restoring divider, configuration and output registers. Depends on psic_pkg.
`default_nettype none
module psic_datapath (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire  psic_pkg::cmd_t    cmd_i,
  output psic_pkg::status_t       status_o,
  input  wire                     cfg_we_i,
  input  wire  [1:0]              cfg_addr_i,
  input  wire  [15:0]             cfg_wdata_i,
  input  wire  [1:0]              coef_segment_i,
  input  wire  [3:0]              coef_index_i,
  input  wire  signed [31:0]      coef_value_i,
  input  wire  [15:0]             raw_intensity_i,
  input  wire  [15:0]             range_m_i,
  input  wire  signed [15:0]      cos_incidence_i,
  input  wire                     out_ready_i,
  output logic                    out_valid_o,
  output logic [15:0]             corrected_intensity_o,
  output logic signed [31:0]      model_intensity_o,
  output logic                    divide_fault_o
);

  logic [15:0] near_q, far_q, gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= psic_pkg::NEAR_LIMIT_RST;
      far_q  <= psic_pkg::FAR_LIMIT_RST;
      gain_q <= psic_pkg::REF_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        psic_pkg::REG_NEAR_LIMIT: near_q <= cfg_wdata_i;
        psic_pkg::REG_FAR_LIMIT:  far_q  <= cfg_wdata_i;
        psic_pkg::REG_REF_GAIN:   gain_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Coefficient memory, no reset.
  logic signed [31:0]          mem [psic_pkg::TABLE_DEPTH];
  logic signed [31:0]          rd_q;
  logic [psic_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic                        wr_ok;
  logic [1:0]                  seg_q, seg_d;

  assign wr_ok = (32'(coef_segment_i) < 32'(psic_pkg::SEGMENTS)) &&
                 (32'(coef_index_i) < 32'(psic_pkg::TERMS));
  assign wr_addr = psic_pkg::ADDR_W'(coef_segment_i) * psic_pkg::ADDR_W'(psic_pkg::TERMS)
                 + psic_pkg::ADDR_W'(coef_index_i);
  assign rd_addr = psic_pkg::ADDR_W'(seg_q) * psic_pkg::ADDR_W'(psic_pkg::TERMS)
                 + psic_pkg::ADDR_W'(cmd_i.term);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_coef && wr_ok) begin
      mem[wr_addr] <= coef_value_i;
    end
    if (cmd_i.fetch) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    if (range_m_i <= near_q) begin
      seg_d = 2'd0;
    end else if (range_m_i <= far_q) begin
      seg_d = 2'd1;
    end else begin
      seg_d = 2'd2;
    end
    if (32'(seg_d) > 32'(psic_pkg::SEGMENTS - 1)) begin
      seg_d = 2'(psic_pkg::SEGMENTS - 1);
    end
  end

  // Point registers and polynomial state.
  logic [15:0]        range_q;
  logic signed [15:0] x_q;
  logic [42:0]        num_q;
  logic signed [16:0] xp_q;
  logic [31:0]        yp_q;
  logic signed [48:0] p1_q;
  logic signed [65:0] p2_q;
  logic signed [63:0] fit_q;

  logic signed [48:0] p1_d, a_full;
  logic signed [32:0] a_val;
  logic signed [65:0] p2_d, t_full;
  logic signed [33:0] xx, xr;
  logic [48:0]        yy;
  logic [40:0]        ys;
  logic [31:0]        yp_next;

  assign p1_d    = rd_q * xp_q;
  assign a_full  = (p1_q + 49'sd16384) >>> 15;
  assign a_val   = a_full[32:0];
  assign p2_d    = a_val * $signed({1'b0, yp_q});
  assign t_full  = (p2_q + 66'sd128) >>> 8;
  assign xx      = xp_q * x_q;
  assign xr      = (xx + 34'sd16384) >>> 15;
  assign yy      = yp_q * range_q + 49'd128;
  assign ys      = yy[48:8];
  assign yp_next = (|ys[40:32]) ? 32'hFFFF_FFFF : ys[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_point) begin
      range_q <= range_m_i;
      x_q     <= cos_incidence_i;
      seg_q   <= seg_d;
      num_q   <= {32'(raw_intensity_i) * 32'(gain_q), 11'd0};
      xp_q    <= 17'sd32768;
      yp_q    <= 32'd256;
      fit_q   <= '0;
    end
    if (cmd_i.mul1) begin
      p1_q <= p1_d;
    end
    if (cmd_i.mul2) begin
      p2_q <= p2_d;
    end
    if (cmd_i.acc) begin
      fit_q <= fit_q + t_full[63:0];
      if (cmd_i.row_end) begin
        yp_q <= 32'd256;
        xp_q <= xr[16:0];
      end else begin
        yp_q <= yp_next;
      end
    end
  end

  // Model output and divider.
  logic signed [63:0] mf;
  logic signed [31:0] model_sat;
  logic [79:0]        fit_ext, num_ext, sh;
  logic               clamp;
  logic [42:0]        rem_q;
  logic [15:0]        quo_q;
  logic signed [31:0] model_q;
  logic               fault_q;

  assign mf = (fit_q + 64'sd1024) >>> 11;
  always_comb begin
    if (mf > 64'sd2147483647) begin
      model_sat = 32'sh7FFF_FFFF;
    end else if (mf < -64'sd2147483648) begin
      model_sat = 32'sh8000_0000;
    end else begin
      model_sat = mf[31:0];
    end
  end

  assign fit_ext = {17'd0, fit_q[62:0]};
  assign num_ext = {37'd0, num_q};
  assign clamp   = num_ext >= (fit_ext << 16);
  assign sh      = fit_ext << cmd_i.k;
  assign status_o.skip_div = (fit_q <= 64'sd0) || clamp;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= num_q;
      if (fit_q == 64'sd0) begin
        model_q <= '0;
        fault_q <= 1'b1;
        quo_q   <= 16'hFFFF;
      end else begin
        model_q <= model_sat;
        fault_q <= 1'b0;
        if (fit_q < 64'sd0) begin
          quo_q <= '0;
        end else if (clamp) begin
          quo_q <= 16'hFFFF;
        end else begin
          quo_q <= '0;
        end
      end
    end
    if (cmd_i.div_step && ({37'd0, rem_q} >= sh)) begin
      rem_q <= rem_q - sh[42:0];
      quo_q[cmd_i.k] <= 1'b1;
    end
  end

  // Output register.
  logic out_valid_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      corrected_intensity_o <= quo_q;
      model_intensity_o     <= model_q;
      divide_fault_o        <= fault_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/piecewise_surface_intensity_correct.sv =====
// Top level of the piecewise surface intensity correction block.
// Depends on psic_pkg, psic_ctrl and psic_datapath.
//
// Channel    Dir  Handshake                  Contents
// s_axis     in   tvalid/tready              tuser: mode; tdata: coefficient or point
// m_axis     out  tvalid/tready              tuser: divide_fault; tdata: intensities
// cfg        in   cfg_we_i (no wait)         near_limit, far_limit, reference_gain
//
// A load request (mode 0) is written as it is taken and leaves the block ready. A
// point request walks the nine polynomial terms, each through the shared
// read-multiply-multiply-accumulate sequence, then one setup step and sixteen
// restoring divider steps; zero, negative or clamped fits skip the divider
// steps. The output register lets a new request be taken while a
// result waits; a stalled result only holds the sequencer at its final step.
// Reset restores the configuration defaults; the coefficient memory is not cleared.
`default_nettype none
module piecewise_surface_intensity_correct (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] coef_segment, [5:2] coef_index, [37:6] coef_value,
  // [53:38] raw_intensity, [69:54] range_m, [85:70] cos_incidence, [87:86] zero
  input  wire  [87:0] s_axis_tdata_i,
  // [0] mode
  input  wire  [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // [15:0] corrected_intensity, [47:16] model_intensity
  output logic [47:0] m_axis_tdata_o,
  // [0] divide_fault
  output logic [0:0]  m_axis_tuser_o,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_addr_i,
  input  wire  [15:0] cfg_wdata_i
);

  psic_pkg::cmd_t    cmd;
  psic_pkg::status_t status;
  logic [15:0]        corrected;
  logic signed [31:0] model;
  logic               fault;

  psic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_mode_i  (s_axis_tuser_i[0]),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  psic_datapath u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .cfg_we_i              (cfg_we_i),
    .cfg_addr_i            (cfg_addr_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .coef_segment_i        (s_axis_tdata_i[1:0]),
    .coef_index_i          (s_axis_tdata_i[5:2]),
    .coef_value_i          ($signed(s_axis_tdata_i[37:6])),
    .raw_intensity_i       (s_axis_tdata_i[53:38]),
    .range_m_i             (s_axis_tdata_i[69:54]),
    .cos_incidence_i       ($signed(s_axis_tdata_i[85:70])),
    .out_ready_i           (m_axis_tready_i),
    .out_valid_o           (m_axis_tvalid_o),
    .corrected_intensity_o (corrected),
    .model_intensity_o     (model),
    .divide_fault_o        (fault)
  );

  assign m_axis_tdata_o = {model, corrected};
  assign m_axis_tuser_o = fault;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for piecewise_surface_intensity_correct.
// Depends on psic_pkg and the RTL top level; the expected results come from a
// behavioral predictor of the fixed-point correction kept inside this module, or are typed into the directed table.
`default_nettype none
module testbench;

  localparam int STALL_LIMIT = 5000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT  = 200;   // cycles kept after the last result
  localparam int CFG_SETTLE  = 80;    // longer than a full point computation
  localparam int HOLD_CYCLES = 600;   // long receiver hold-off

  // Result fields as they appear on the master side.
  typedef struct {
    logic [15:0]        corr;
    logic signed [31:0] model;
    logic               fault;
  } result_t;

  // One row of the directed table; when has_exp is set the expected result is
  // typed in and replaces the predicted one.
  typedef struct {
    logic               mode;
    logic [1:0]         seg;
    logic [3:0]         idx;
    logic signed [31:0] coef;
    logic [15:0]        raw;
    logic [15:0]        rng;
    logic signed [15:0] cosv;
    bit                 has_exp;
    result_t            exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [87:0] s_data = '0;
  logic [0:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [47:0] m_axis_tdata_o;
  wire  [0:0]  m_axis_tuser_o;

  piecewise_surface_intensity_correct u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the block's configuration and coefficient memory.
  logic [15:0]        near_lim;
  logic [15:0]        far_lim;
  logic [15:0]        gain;
  logic signed [31:0] coef_mem [psic_pkg::TABLE_DEPTH];

  result_t pending_results[$];
  row_t    rows[$];
  int      err_count = 0;
  int      sender_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      hold_go = 1'b0;
  bit      hold_seen = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // Appends one expected result behind those still outstanding.
  function automatic void queue_result(input result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic void add_row(input row_t r);
    rows = {rows, r};
  endfunction

  // Applies one request to the shadow state. Returns 1 and fills res when the
  // request is a point correction.
  function automatic bit correct_point(input logic mode, input logic [87:0] d,
                                       output result_t res);
    logic [1:0]  seg;
    logic [3:0]  idx;
    longint      raw, rng, x, xp, yp, a, fit, mdl, num, corr;
    int          sel;
    seg = d[1:0];
    idx = d[5:2];
    res = '{corr: '0, model: '0, fault: 1'b0};
    if (mode == psic_pkg::MODE_LOAD) begin
      // Addresses outside the table are dropped silently.
      if (seg < psic_pkg::SEGMENTS && idx < psic_pkg::TERMS)
        coef_mem[seg * psic_pkg::TERMS + idx] = d[37:6];
      return 1'b0;
    end
    raw = d[53:38];
    rng = d[69:54];
    x   = longint'($signed(d[85:70]));
    if (rng <= near_lim) sel = 0;
    else if (rng <= far_lim) sel = 1;
    else sel = 2;
    if (sel > psic_pkg::SEGMENTS - 1) sel = psic_pkg::SEGMENTS - 1;
    fit = 0;
    xp = 32768;
    for (int i = 0; i <= psic_pkg::DEGREE_X; i++) begin
      yp = 256;
      for (int j = 0; j <= psic_pkg::DEGREE_Y; j++) begin
        a = round_shift(longint'(coef_mem[sel * psic_pkg::TERMS +
                                          i * (psic_pkg::DEGREE_Y + 1) + j]) * xp, 15);
        fit += round_shift(a * yp, 8);
        yp = (yp * rng + 128) >>> 8;
        if (yp > 64'sh0000_0000_FFFF_FFFF) yp = 64'sh0000_0000_FFFF_FFFF;
      end
      xp = round_shift(xp * x, 15);
    end
    mdl = round_shift(fit, 11);
    if (mdl > 64'sh0000_0000_7FFF_FFFF) mdl = 64'sh0000_0000_7FFF_FFFF;
    if (mdl < -64'sh0000_0000_8000_0000) mdl = -64'sh0000_0000_8000_0000;
    if (fit == 0) begin
      res.fault = 1'b1;
      corr = 65535;
    end else if (fit < 0) begin
      corr = 0;
    end else begin
      num = raw * longint'(gain) * 2048;
      corr = num / fit;
      if (corr > 65535) corr = 65535;
    end
    res.corr  = corr[15:0];
    res.model = mdl[31:0];
    return 1'b1;
  endfunction

  function automatic logic [87:0] pack_request(logic [1:0] seg, logic [3:0] idx,
      logic [31:0] coef, logic [15:0] raw, logic [15:0] rng, logic [15:0] cosv);
    return {2'b00, cosv, rng, raw, coef, idx, seg};
  endfunction

  // Offers one request and waits until it is taken. The valid line stays high
  // on return so that back-to-back requests need no second assignment.
  task automatic send_request(input logic mode, input logic [87:0] d,
                              output bit has_res, output result_t res);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= mode;
    s_data  <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    has_res = correct_point(mode, d, res);
  endtask

  task automatic send_and_expect(input logic mode, input logic [87:0] d);
    bit      has_res;
    result_t res;
    send_request(mode, d, has_res, res);
    if (has_res) queue_result(res);
  endtask

  // Waits for every expected result, then for any load still in flight.
  task automatic wait_idle();
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (addr)
      psic_pkg::REG_NEAR_LIMIT: near_lim = val;
      psic_pkg::REG_FAR_LIMIT:  far_lim  = val;
      psic_pkg::REG_REF_GAIN:   gain     = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] n, input logic [15:0] f,
                            input logic [15:0] g);
    write_reg(psic_pkg::REG_NEAR_LIMIT, n);
    write_reg(psic_pkg::REG_FAR_LIMIT, f);
    write_reg(psic_pkg::REG_REF_GAIN, g);
  endtask

  // Random coefficient: full range, small values that keep the fit moderate,
  // or an extreme.
  function automatic logic [31:0] pick_coef();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 8) return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Ranges cluster around the two thresholds so each segment boundary is hit.
  function automatic logic [15:0] pick_range();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 16'($urandom_range(0, 65535));
    if (sel < 6) return 16'(near_lim + $urandom_range(0, 4) - 2);
    if (sel < 8) return 16'(far_lim + $urandom_range(0, 4) - 2);
    if (sel < 9) return 16'($urandom_range(0, 4000));
    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic random_requests(input int count);
    logic [1:0]  seg;
    logic [3:0]  idx;
    logic [15:0] cosv;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 35) begin
        // Mostly well-formed loads; some go to addresses the block must drop.
        if ($urandom_range(0, 9) == 0) begin
          seg = 2'($urandom_range(0, 3));
          idx = 4'($urandom_range(0, 15));
        end else begin
          seg = 2'($urandom_range(0, psic_pkg::SEGMENTS - 1));
          idx = 4'($urandom_range(0, psic_pkg::TERMS - 1));
        end
        send_and_expect(psic_pkg::MODE_LOAD,
                        pack_request(seg, idx, pick_coef(), 16'($urandom),
                                     16'($urandom), 16'($urandom)));
      end else begin
        case ($urandom_range(0, 5))
          0: cosv = 16'h7FFF;
          1: cosv = 16'h8000;
          default: cosv = 16'($urandom);
        endcase
        send_and_expect(psic_pkg::MODE_CORRECT,
                        pack_request(2'($urandom), 4'($urandom), $urandom,
                                     16'($urandom), pick_range(), cosv));
      end
    end
  endtask

  // Result side: compare every accepted result with the oldest expectation,
  // then choose the ready level for the next cycle. A requested hold-off is
  // counted down here, independent of the sender.
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: corrected_intensity %0d model_intensity %0d",
               m_axis_tdata_o[15:0], $signed(m_axis_tdata_o[47:16]));
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata_o[15:0] !== exp_res.corr) begin
          $error("corrected_intensity: expected %0d, got %0d", exp_res.corr,
                 m_axis_tdata_o[15:0]);
          err_count++;
        end
        if (m_axis_tdata_o[47:16] !== exp_res.model) begin
          $error("model_intensity: expected %0d, got %0d", exp_res.model,
                 $signed(m_axis_tdata_o[47:16]));
          err_count++;
        end
        if (m_axis_tuser_o[0] !== exp_res.fault) begin
          $error("divide_fault: expected %0d, got %0d", exp_res.fault,
                 m_axis_tuser_o[0]);
          err_count++;
        end
      end
    end
    if (hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: the run is stuck if no request, result or register write moves
  // for too long.
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) || cfg_we || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    bit      has_res;
    result_t res;

    near_lim = psic_pkg::NEAR_LIMIT_RST;
    far_lim  = psic_pkg::FAR_LIMIT_RST;
    gain     = psic_pkg::REF_GAIN_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every coefficient is written before any point is corrected, since the
    // memory is not cleared by reset. All segments start at zero.
    for (int k = 0; k < psic_pkg::TABLE_DEPTH; k++)
      send_and_expect(psic_pkg::MODE_LOAD,
                      pack_request(2'(k / psic_pkg::TERMS), 4'(k % psic_pkg::TERMS),
                                   '0, '0, '0, '0));

    // Directed part, with the default configuration.
    // All-zero table: every point hits a zero fit and saturates.
    add_row('{psic_pkg::MODE_CORRECT, 2'd3, 4'd15, -1, 16'hFFFF, 16'd0, 16'sh7FFF,
              1, '{16'hFFFF, 0, 1'b1}});
    add_row('{psic_pkg::MODE_CORRECT, 2'd0, 4'd0, 0, 16'h0000, 16'hFFFF, -16'sh8000,
              1, '{16'hFFFF, 0, 1'b1}});
    // Constant term 1.0 in the near segment: fit 65536, model 32.
    add_row('{psic_pkg::MODE_LOAD, 2'd0, 4'd0, 32'sh0001_0000, 16'hFFFF, 16'hFFFF, -1,
              0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_CORRECT, 2'd0, 4'd0, 0, 16'h0000, 16'd0, 16'sh0000,
              1, '{16'h0000, 32, 1'b0}});
    // Range equal to the near limit still picks the near segment; clamps high.
    add_row('{psic_pkg::MODE_CORRECT, 2'd0, 4'd0, 0, 16'hFFFF, 16'd1459, 16'sh0000,
              1, '{16'hFFFF, 32, 1'b0}});
    // Loads to addresses outside the table must leave it untouched.
    add_row('{psic_pkg::MODE_LOAD, 2'd3, 4'd0, -1, 0, 0, 0, 0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_LOAD, 2'd0, 4'd9, -1, 0, 0, 0, 0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_LOAD, 2'd0, 4'd15, -1, 0, 0, 0, 0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_CORRECT, 2'd3, 4'd15, -1, 16'hFFFF, 16'd0, 16'sh0000,
              1, '{16'hFFFF, 32, 1'b0}});
    // Negative fit clamps the corrected intensity at zero without a fault.
    add_row('{psic_pkg::MODE_LOAD, 2'd0, 4'd0, -32'sh0001_0000, 0, 0, 0, 0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_CORRECT, 2'd0, 4'd0, 0, 16'hFFFF, 16'd0, 16'sh0000,
              1, '{16'h0000, -32, 1'b0}});
    // Extreme coefficients, cosines and ranges, checked by the predictor.
    add_row('{psic_pkg::MODE_LOAD, 2'd0, 4'd0, 32'sh7FFF_FFFF, 0, 0, 0, 0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_CORRECT, 0, 0, 0, 16'hFFFF, 16'd1459, 16'sh7FFF,
              0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_LOAD, 2'd1, 4'd8, -32'sh8000_0000, 0, 0, 0, 0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_CORRECT, 0, 0, 0, 16'hFFFF, 16'd1460, -16'sh8000,
              0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_LOAD, 2'd1, 4'd4, 32'sd12345678, 0, 0, 0, 0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_CORRECT, 0, 0, 0, 16'd30000, 16'd3635, 16'sh4000,
              0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_LOAD, 2'd2, 4'd2, 32'sh0001_0000, 0, 0, 0, 0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_CORRECT, 0, 0, 0, 16'hFFFF, 16'd3636, 16'sh0000,
              0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_CORRECT, 0, 0, 0, 16'h0001, 16'hFFFF, 16'sh7FFF,
              0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_LOAD, 2'd2, 4'd6, -1, 0, 0, 0, 0, '{0, 0, 0}});
    add_row('{psic_pkg::MODE_CORRECT, 0, 0, 0, 16'h8000, 16'hFFFF, -16'sh0001,
              0, '{0, 0, 0}});

    foreach (rows[r]) begin
      send_request(rows[r].mode, pack_request(rows[r].seg, rows[r].idx, rows[r].coef,
                   rows[r].raw, rows[r].rng, rows[r].cosv), has_res, res);
      if (has_res) queue_result(rows[r].has_exp ? rows[r].exp : res);
    end

    // Random phase one: the sender pauses often, the receiver almost always.
    sender_idle_pct = 27;
    recv_idle_pct   = 87;
    random_requests(480);

    // Extreme thresholds: everything above zero range lands in the middle
    // segment, and the gain is at its maximum.
    wait_idle();
    set_config(16'h0000, 16'hFFFF, 16'hFFFF);
    sender_idle_pct = 87;
    recv_idle_pct   = 27;
    random_requests(480);

    // Inverted thresholds and zero gain.
    wait_idle();
    set_config(16'hFFFF, 16'h0000, 16'h0000);
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    random_requests(200);

    // Random thresholds, no idling, then a long receiver hold-off while the
    // sender keeps offering requests until the block backs up.
    wait_idle();
    set_config(16'($urandom_range(0, 4000)), 16'($urandom_range(2000, 8000)),
               16'($urandom));
    random_requests(250);
    hold_go = 1'b1;
    random_requests(60);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/psic_pkg.sv
rtl/psic_ctrl.sv
rtl/psic_datapath.sv
rtl/piecewise_surface_intensity_correct.sv
tb/sv/testbench.sv
